/* rtl/first_fit_segment_allocator_top_defines.svh */
// Assertion macros shared by the allocator RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define FFSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FFSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ffsa_pkg.sv */
package ffsa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int ADDR_BITS    = 20;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int HB_W         = 8;
  localparam int LIM_W        = ADDR_BITS + 1;
  localparam int SUM_W        = ADDR_BITS + 2;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = CFG_IDX_W'(1);

  localparam logic [HB_W-1:0]  HEADER_RESET = HB_W'(32);
  localparam logic [LIM_W-1:0] ADDR_SPAN    = LIM_W'(1) << ADDR_BITS;
  localparam logic [LIM_W-1:0] LIMIT_RESET  = ADDR_SPAN;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_HEAP   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_GAP,
    OP_APPEND,
    OP_REMOVE
  } seg_op_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } seg_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    seg_op_t              op;
    logic                 shift;
    logic                 launch;
    logic                 clear;
    logic                 is_alloc;
    logic [HB_W-1:0]      hb;
    logic [ADDR_BITS-1:0] req_size;
    logic [ADDR_BITS-1:0] req_addr;
    logic [ADDR_BITS-1:0] new_start;
    logic [ADDR_BITS-1:0] new_len;
    logic [CNT_W-1:0]     count;
  } chain_ctl_t;

  // Scan report of one cell, or of the whole row after reduction.
  typedef struct packed {
    logic                 hit;
    logic                 stop;
    logic [ADDR_BITS-1:0] addr;
  } cell_stat_t;

endpackage

/* rtl/first_fit_segment_allocator_top.sv */
// Channel  | Beat fields                 | Handshake
// request  | cmd, req_size, req_addr     | in_valid / in_stall
// result   | payload_addr, status        | out_valid / out_stall
// config   | wr_index, wr_data           | wr_en, no wait
//
// The accepting edge loads the request. A prep state then settles the per-entry gap and
// match flags while the token is launched into the first cell, then the token walks the
// row of cells until the scan decides and the result register is loaded.
// The insert or remove shift of the whole table happens in the cycle that loads the result.
// Reset clears the entry count, the tail, the configuration registers and the token; entries
// need no clearing. A stalled result holds the final scan step, and the next
// request is taken while a result still waits.
`include "first_fit_segment_allocator_top_defines.svh"

module first_fit_segment_allocator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [ffsa_pkg::ADDR_BITS-1:0]      req_size,
  input  logic [ffsa_pkg::ADDR_BITS-1:0]      req_addr,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ffsa_pkg::ADDR_BITS-1:0]      payload_addr,
  output logic [1:0]                          status,
  input  logic                                wr_en,
  input  logic [ffsa_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [ffsa_pkg::LIM_W-1:0]          wr_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PREP = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [ffsa_pkg::HB_W-1:0]      header_bytes;
  logic [ffsa_pkg::LIM_W-1:0]     heap_limit;
  logic [ffsa_pkg::CNT_W-1:0]     seg_count;
  logic [ffsa_pkg::CNT_W-1:0]     seg_count_next;
  logic [ffsa_pkg::LIM_W-1:0]     tail;
  logic [ffsa_pkg::LIM_W-1:0]     tail_next;
  logic                           req_cmd;
  logic [ffsa_pkg::ADDR_BITS-1:0] req_size_q;
  logic [ffsa_pkg::ADDR_BITS-1:0] req_addr_q;

  ffsa_pkg::chain_ctl_t           ctl;
  ffsa_pkg::cell_stat_t           scan;
  logic [ffsa_pkg::MAX_SEGMENTS-1:0] tok_vec;

  logic                           is_alloc;
  logic                           full_alloc;
  logic                           decide;
  logic                           out_free;
  logic                           finish;
  logic                           accept;
  logic [ffsa_pkg::LIM_W-1:0]     limit;
  logic [ffsa_pkg::SUM_W-1:0]     app_start;
  logic [ffsa_pkg::SUM_W-1:0]     app_end;
  logic                           app_fail;
  ffsa_pkg::seg_op_t              fin_op;
  logic [1:0]                     fin_status;
  logic [ffsa_pkg::ADDR_BITS-1:0] fin_addr;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_alloc   = (req_cmd == ffsa_pkg::CMD_ALLOC);
  assign full_alloc = is_alloc && (seg_count == ffsa_pkg::CNT_W'(ffsa_pkg::MAX_SEGMENTS));
  assign decide     = (state == S_SCAN) && (full_alloc || scan.hit || scan.stop);
  assign out_free   = !out_valid || !out_stall;
  assign finish     = decide && out_free;

  assign limit     = (heap_limit > ffsa_pkg::ADDR_SPAN) ? ffsa_pkg::ADDR_SPAN : heap_limit;
  assign app_start = ffsa_pkg::SUM_W'(tail) + ffsa_pkg::SUM_W'(header_bytes);
  assign app_end   = app_start + ffsa_pkg::SUM_W'(req_size_q);
  assign app_fail  = (app_end > ffsa_pkg::SUM_W'(limit)) ||
                     (app_start >= ffsa_pkg::SUM_W'(ffsa_pkg::ADDR_SPAN));

  always_comb begin
    fin_op     = ffsa_pkg::OP_NONE;
    fin_status = ffsa_pkg::ST_OK;
    fin_addr   = '0;
    priority if (full_alloc) begin
      fin_status = ffsa_pkg::ST_FULL;
    end else if (scan.hit) begin
      if (is_alloc) begin
        fin_op   = ffsa_pkg::OP_GAP;
        fin_addr = scan.addr;
      end else begin
        fin_op   = ffsa_pkg::OP_REMOVE;
      end
    end else if (is_alloc) begin
      if (app_fail) begin
        fin_status = ffsa_pkg::ST_NO_HEAP;
      end else begin
        fin_op   = ffsa_pkg::OP_APPEND;
        fin_addr = app_start[ffsa_pkg::ADDR_BITS-1:0];
      end
    end else begin
      fin_status = ffsa_pkg::ST_NOT_FOUND;
    end
  end

  always_comb begin
    ctl.op        = finish ? fin_op : ffsa_pkg::OP_NONE;
    ctl.launch    = (state == S_PREP);
    ctl.shift     = (state == S_PREP) || ((state == S_SCAN) && !decide);
    ctl.clear     = finish;
    ctl.is_alloc  = is_alloc;
    ctl.hb        = header_bytes;
    ctl.req_size  = req_size_q;
    ctl.req_addr  = req_addr_q;
    ctl.new_start = fin_addr;
    ctl.new_len   = req_size_q;
    ctl.count     = seg_count;
  end

  ffsa_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .stat    (scan),
    .tok_vec (tok_vec)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_PREP;
      S_PREP:  state_next = S_SCAN;
      S_SCAN:  if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    seg_count_next = seg_count;
    tail_next      = tail;
    if (finish) begin
      unique case (fin_op)
        ffsa_pkg::OP_GAP:    seg_count_next = seg_count + 1'b1;
        ffsa_pkg::OP_APPEND: begin
          seg_count_next = seg_count + 1'b1;
          tail_next      = app_end[ffsa_pkg::LIM_W-1:0];
        end
        ffsa_pkg::OP_REMOVE: seg_count_next = seg_count - 1'b1;
        default:             seg_count_next = seg_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_count <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      seg_count <= seg_count_next;
      tail      <= tail_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= ffsa_pkg::HEADER_RESET;
      heap_limit   <= ffsa_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      if (wr_index == ffsa_pkg::CFG_HEADER_BYTES) begin
        header_bytes <= wr_data[ffsa_pkg::HB_W-1:0];
      end else if (wr_index == ffsa_pkg::CFG_HEAP_LIMIT) begin
        heap_limit <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd    <= cmd;
      req_size_q <= req_size;
      req_addr_q <= req_addr;
    end
    if (finish) begin
      payload_addr <= fin_addr;
      status       <= fin_status;
    end
  end

  `FFSA_ASSERT_IMP(a_one_token, 1'b1, $onehot0(tok_vec), "more than one scan token in the row")
  `FFSA_ASSERT_IMP(a_no_token_idle, state != S_SCAN, tok_vec == '0, "token present outside scan")
  `FFSA_ASSERT_NXT(a_alloc_count, finish && is_alloc && fin_status == ffsa_pkg::ST_OK, seg_count == $past(seg_count) + 1'b1, "allocate did not grow table")
  `FFSA_ASSERT_IMP(a_tail_grows, !$past(rst), tail >= $past(tail), "tail moved back")

endmodule

/* rtl/ffsa_cell.sv */
module ffsa_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ffsa_pkg::IDX_W-1:0]  cell_idx,
  input  ffsa_pkg::chain_ctl_t        ctl,
  input  logic                        tok_left,
  input  logic                        keep_left,
  input  ffsa_pkg::seg_t              left,
  input  ffsa_pkg::seg_t              right,
  input  logic                        right_valid,
  output ffsa_pkg::seg_t              seg,
  output logic                        tok,
  output logic                        keep,
  output logic                        valid,
  output ffsa_pkg::cell_stat_t        stat
);

  ffsa_pkg::seg_t seg_next;
  logic           prior;
  logic           gap_q;
  logic           match_q;
  logic [ffsa_pkg::ADDR_BITS:0]   seg_end;
  logic [ffsa_pkg::SUM_W-1:0]     end_hb;
  logic [ffsa_pkg::SUM_W-1:0]     end_need;
  logic [ffsa_pkg::SUM_W-1:0]     right_ext;
  logic                           gap;

  assign valid = ctl.count > ffsa_pkg::CNT_W'(cell_idx);

  // Gap test against the right neighbor's header.
  assign seg_end   = {1'b0, seg.start} + {1'b0, seg.len};
  assign end_hb    = {1'b0, seg_end} + ffsa_pkg::SUM_W'(ctl.hb);
  assign end_need  = end_hb + ffsa_pkg::SUM_W'(ctl.hb) + ffsa_pkg::SUM_W'(ctl.req_size);
  assign right_ext = ffsa_pkg::SUM_W'(right.start);
  assign gap       = right_valid && (right_ext > end_hb) && (right_ext >= end_need);

  always_comb begin
    unique case (ctl.op)
      ffsa_pkg::OP_NONE:   keep = 1'b1;
      ffsa_pkg::OP_GAP:    keep = prior | tok;
      ffsa_pkg::OP_APPEND: keep = valid;
      ffsa_pkg::OP_REMOVE: keep = prior;
      default:             keep = 1'b1;
    endcase
  end

  always_comb begin
    seg_next = seg;
    if (!keep) begin
      if (ctl.op == ffsa_pkg::OP_REMOVE) begin
        seg_next = right;
      end else if (keep_left) begin
        seg_next.start = ctl.new_start;
        seg_next.len   = ctl.new_len;
      end else begin
        seg_next = left;
      end
    end
  end

  always_comb begin
    stat.hit  = tok && (ctl.is_alloc ? gap_q : match_q);
    stat.stop = tok && (ctl.is_alloc ? !right_valid : (!valid || !right_valid));
    stat.addr = (tok && ctl.is_alloc && gap_q) ? end_hb[ffsa_pkg::ADDR_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    seg     <= seg_next;
    gap_q   <= gap;
    match_q <= valid && (seg.start == ctl.req_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= 1'b0;
      prior <= 1'b0;
    end else if (ctl.clear) begin
      tok   <= 1'b0;
      prior <= 1'b0;
    end else if (ctl.shift) begin
      tok   <= tok_left;
      prior <= prior | tok;
    end
  end

endmodule

/* rtl/ffsa_chain.sv */
module ffsa_chain (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ffsa_pkg::chain_ctl_t                   ctl,
  output ffsa_pkg::cell_stat_t                   stat,
  output logic [ffsa_pkg::MAX_SEGMENTS-1:0]      tok_vec
);

  localparam int N = ffsa_pkg::MAX_SEGMENTS;

  ffsa_pkg::seg_t       seg_w   [N];
  ffsa_pkg::seg_t       left_w  [N];
  ffsa_pkg::seg_t       right_w [N];
  ffsa_pkg::cell_stat_t stat_w  [N];
  logic [N-1:0]         tok_w;
  logic [N-1:0]         keep_w;
  logic [N-1:0]         valid_w;
  logic [N-1:0]         tok_l;
  logic [N-1:0]         keep_l;
  logic [N-1:0]         valid_r;

  for (genvar j = 0; j < N; j++) begin : g_cell
    if (j == 0) begin : g_first
      assign tok_l[j]  = ctl.launch;
      assign keep_l[j] = 1'b1;
      assign left_w[j] = '0;
    end else begin : g_inner_l
      assign tok_l[j]  = tok_w[j-1];
      assign keep_l[j] = keep_w[j-1];
      assign left_w[j] = seg_w[j-1];
    end
    if (j == N - 1) begin : g_last
      assign right_w[j] = '0;
      assign valid_r[j] = 1'b0;
    end else begin : g_inner_r
      assign right_w[j] = seg_w[j+1];
      assign valid_r[j] = valid_w[j+1];
    end

    ffsa_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_idx    (ffsa_pkg::IDX_W'(j)),
      .ctl         (ctl),
      .tok_left    (tok_l[j]),
      .keep_left   (keep_l[j]),
      .left        (left_w[j]),
      .right       (right_w[j]),
      .right_valid (valid_r[j]),
      .seg         (seg_w[j]),
      .tok         (tok_w[j]),
      .keep        (keep_w[j]),
      .valid       (valid_w[j]),
      .stat        (stat_w[j])
    );
  end

  // Only the cell holding the token reports, so a plain OR merges the row.
  always_comb begin
    stat = '0;
    for (int j = 0; j < N; j++) begin
      stat.hit  = stat.hit  | stat_w[j].hit;
      stat.stop = stat.stop | stat_w[j].stop;
      stat.addr = stat.addr | stat_w[j].addr;
    end
  end

  assign tok_vec = tok_w;

endmodule

/* tb/sv/first_fit_segment_allocator_top_test.sv */
`timescale 1ns / 1ps

module first_fit_segment_allocator_top_test;

  localparam int          RUN_LIMIT       = 1000000;
  localparam int          SETTLE_CYCLES   = ffsa_pkg::MAX_SEGMENTS + 8;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          PHASES          = 8;
  localparam int          ITEMS_PER_PHASE = 120;
  localparam logic [ffsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = ffsa_pkg::CFG_IDX_W'(2);
  localparam logic [ffsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = ffsa_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    logic [ffsa_pkg::ADDR_BITS-1:0] payload_addr;
    logic [1:0]                     status;
  } grant_t;

  // Mirror of the segment table: predicts the result of every accepted request
  // and holds the predictions until the block answers them in order.
  class alloc_tracker;
    logic [ffsa_pkg::ADDR_BITS-1:0] seg_start [ffsa_pkg::MAX_SEGMENTS];
    logic [ffsa_pkg::ADDR_BITS-1:0] seg_len [ffsa_pkg::MAX_SEGMENTS];
    int                             live;
    logic [ffsa_pkg::LIM_W-1:0]     tail;
    logic [ffsa_pkg::HB_W-1:0]      hdr;
    logic [ffsa_pkg::LIM_W-1:0]     heap_cap;
    logic [ffsa_pkg::ADDR_BITS-1:0] last_grant;
    grant_t                         grants_due[$];
    int                             errors;

    function new();
      live       = 0;
      tail       = '0;
      hdr        = ffsa_pkg::HEADER_RESET;
      heap_cap   = ffsa_pkg::LIMIT_RESET;
      last_grant = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [ffsa_pkg::CFG_IDX_W-1:0] idx,
                            logic [ffsa_pkg::LIM_W-1:0] val);
      if (idx == ffsa_pkg::CFG_HEADER_BYTES) begin
        hdr = val[ffsa_pkg::HB_W-1:0];
      end else if (idx == ffsa_pkg::CFG_HEAP_LIMIT) begin
        heap_cap = val;
      end
    endfunction

    function void place(int pos, logic [ffsa_pkg::ADDR_BITS-1:0] start,
                        logic [ffsa_pkg::ADDR_BITS-1:0] len);
      int k;
      for (k = live; k > pos; k--) begin
        seg_start[k] = seg_start[k-1];
        seg_len[k]   = seg_len[k-1];
      end
      seg_start[pos] = start;
      seg_len[pos]   = len;
      live++;
      last_grant = start;
    endfunction

    function grant_t carve(logic [ffsa_pkg::ADDR_BITS-1:0] size);
      logic [ffsa_pkg::SUM_W-1:0] seg_end;
      logic [ffsa_pkg::SUM_W-1:0] nxt;
      logic [ffsa_pkg::SUM_W-1:0] start;
      logic [ffsa_pkg::SUM_W-1:0] room;
      grant_t                     g;
      int                         i;
      g.payload_addr = '0;
      g.status       = ffsa_pkg::ST_FULL;
      if (live >= ffsa_pkg::MAX_SEGMENTS) return g;
      g.status = ffsa_pkg::ST_OK;
      // Only gaps between neighbors count; the space before the first entry is skipped.
      for (i = 0; i + 1 < live; i++) begin
        seg_end = ffsa_pkg::SUM_W'(seg_start[i]) + ffsa_pkg::SUM_W'(seg_len[i]);
        nxt     = ffsa_pkg::SUM_W'(seg_start[i+1]);
        if (nxt > seg_end + ffsa_pkg::SUM_W'(hdr) &&
            nxt >= seg_end + ffsa_pkg::SUM_W'(hdr) + ffsa_pkg::SUM_W'(hdr) +
                   ffsa_pkg::SUM_W'(size)) begin
          start = seg_end + ffsa_pkg::SUM_W'(hdr);
          place(i + 1, start[ffsa_pkg::ADDR_BITS-1:0], size);
          g.payload_addr = start[ffsa_pkg::ADDR_BITS-1:0];
          return g;
        end
      end
      room  = (heap_cap < ffsa_pkg::ADDR_SPAN) ? ffsa_pkg::SUM_W'(heap_cap) :
                                                 ffsa_pkg::SUM_W'(ffsa_pkg::ADDR_SPAN);
      start = ffsa_pkg::SUM_W'(tail) + ffsa_pkg::SUM_W'(hdr);
      if (start + ffsa_pkg::SUM_W'(size) > room ||
          start >= ffsa_pkg::SUM_W'(ffsa_pkg::ADDR_SPAN)) begin
        g.status = ffsa_pkg::ST_NO_HEAP;
        return g;
      end
      place(live, start[ffsa_pkg::ADDR_BITS-1:0], size);
      tail = ffsa_pkg::LIM_W'(start + ffsa_pkg::SUM_W'(size));
      g.payload_addr = start[ffsa_pkg::ADDR_BITS-1:0];
      return g;
    endfunction

    function grant_t drop(logic [ffsa_pkg::ADDR_BITS-1:0] addr);
      grant_t g;
      int     i;
      int     k;
      g.payload_addr = '0;
      g.status       = ffsa_pkg::ST_NOT_FOUND;
      for (i = 0; i < live; i++) begin
        if (seg_start[i] == addr) begin
          for (k = i; k + 1 < live; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_len[k]   = seg_len[k+1];
          end
          live--;
          g.status = ffsa_pkg::ST_OK;
          return g;
        end
      end
      return g;
    endfunction

    function void note_request(logic c, logic [ffsa_pkg::ADDR_BITS-1:0] size,
                               logic [ffsa_pkg::ADDR_BITS-1:0] addr);
      if (c == ffsa_pkg::CMD_ALLOC) begin
        grants_due.push_back(carve(size));
      end else begin
        grants_due.push_back(drop(addr));
      end
    endfunction

    task report(string what);
      if (errors < 100) $display("ERROR: %s", what);
      errors++;
    endtask

    task check_result(logic [ffsa_pkg::ADDR_BITS-1:0] addr, logic [1:0] st);
      grant_t want;
      if (grants_due.size() == 0) begin
        report($sformatf("unexpected result beat: payload_addr %0d status %0d", addr, st));
        return;
      end
      want = grants_due.pop_front();
      if (addr !== want.payload_addr) begin
        report($sformatf("payload_addr %0d, expected %0d", addr, want.payload_addr));
      end
      if (st !== want.status) begin
        report($sformatf("status %0d, expected %0d", st, want.status));
      end
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             cmd = ffsa_pkg::CMD_ALLOC;
  logic [ffsa_pkg::ADDR_BITS-1:0]   req_size = '0;
  logic [ffsa_pkg::ADDR_BITS-1:0]   req_addr = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [ffsa_pkg::ADDR_BITS-1:0]   payload_addr;
  logic [1:0]                       status;
  logic                             wr_en = 1'b0;
  logic [ffsa_pkg::CFG_IDX_W-1:0]   wr_index = ffsa_pkg::CFG_HEADER_BYTES;
  logic [ffsa_pkg::LIM_W-1:0]       wr_data = '0;

  logic                 hold_off_req = 1'b0;
  int unsigned          cycle_count = 0;
  alloc_tracker         tracker = new();

  first_fit_segment_allocator_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .req_size     (req_size),
    .req_addr     (req_addr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_addr (payload_addr),
    .status       (status),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(payload_addr, status);
  end

  // Result side: random stalls, long quiet stretches, and a long hold-off on request.
  initial begin
    int stall_left;
    int quiet_left;
    int r;
    stall_left = 0;
    quiet_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (quiet_left > 0) begin
          quiet_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            stall_left = $urandom_range(1, 3);
          end else if (r < 10) begin
            stall_left = $urandom_range(20, 80);
          end else if (r < 12) begin
            quiet_left = $urandom_range(100, 300);
          end
        end
      end
    end
  end

  // Returns at the edge that accepts the beat; the caller decides what valid does next.
  task automatic send_request(input logic c, input logic [ffsa_pkg::ADDR_BITS-1:0] size,
                              input logic [ffsa_pkg::ADDR_BITS-1:0] addr);
    in_valid <= 1'b1;
    cmd      <= c;
    req_size <= size;
    req_addr <= addr;
    do @(posedge clk); while (in_stall);
    tracker.note_request(c, size, addr);
  endtask

  task automatic request_alloc(input logic [ffsa_pkg::ADDR_BITS-1:0] size);
    send_request(ffsa_pkg::CMD_ALLOC, size, ffsa_pkg::ADDR_BITS'($urandom));
  endtask

  task automatic request_free(input logic [ffsa_pkg::ADDR_BITS-1:0] addr);
    send_request(ffsa_pkg::CMD_FREE, ffsa_pkg::ADDR_BITS'($urandom), addr);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [ffsa_pkg::HB_W-1:0] hb,
                              input logic [ffsa_pkg::LIM_W-1:0] cap);
    logic [ffsa_pkg::LIM_W-1:0] hb_word;
    hb_word = {(ffsa_pkg::LIM_W-ffsa_pkg::HB_W)'($urandom), hb};
    wr_en    <= 1'b1;
    wr_index <= ffsa_pkg::CFG_HEADER_BYTES;
    wr_data  <= hb_word;
    @(posedge clk);
    wr_index <= ffsa_pkg::CFG_HEAP_LIMIT;
    wr_data  <= cap;
    @(posedge clk);
    // Indexes past the register list must leave both registers alone.
    wr_index <= $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
    wr_data  <= ffsa_pkg::LIM_W'($urandom);
    @(posedge clk);
    wr_en <= 1'b0;
    tracker.write_reg(ffsa_pkg::CFG_HEADER_BYTES, hb_word);
    tracker.write_reg(ffsa_pkg::CFG_HEAP_LIMIT, cap);
  endtask

  initial begin
    int                             r;
    int                             n;
    int                             fill_pct;
    bit                             steady;
    logic [ffsa_pkg::ADDR_BITS-1:0] size;
    logic [ffsa_pkg::ADDR_BITS-1:0] addr;
    logic [ffsa_pkg::HB_W-1:0]      phase_hb;
    logic [ffsa_pkg::LIM_W-1:0]     phase_cap;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset header of 32: build a short table, open a gap, refill it at and past
    // its exact fit, miss on free, and drop the head entry.
    request_alloc('0);
    request_alloc('1);
    request_alloc(ffsa_pkg::ADDR_BITS'(100));
    request_alloc(ffsa_pkg::ADDR_BITS'(50));
    request_alloc(ffsa_pkg::ADDR_BITS'(10));
    request_free(ffsa_pkg::ADDR_BITS'(196));
    request_alloc(ffsa_pkg::ADDR_BITS'(51));
    request_alloc(ffsa_pkg::ADDR_BITS'(50));
    request_free(ffsa_pkg::ADDR_BITS'(196));
    request_free(ffsa_pkg::ADDR_BITS'(196));
    request_free('1);
    request_free(ffsa_pkg::ADDR_BITS'(32));
    request_alloc('0);

    // With no header, zero-size segments can share one address.
    settle();
    program_regs('0, ffsa_pkg::LIMIT_RESET);
    request_alloc('0);
    request_alloc('0);
    request_free(tracker.last_grant);
    request_free(tracker.last_grant);
    request_free(tracker.last_grant);

    settle();
    program_regs('0, '0);
    request_alloc(ffsa_pkg::ADDR_BITS'(5));
    request_alloc(ffsa_pkg::ADDR_BITS'(200000));

    settle();
    program_regs('1, '1);
    request_alloc(ffsa_pkg::ADDR_BITS'(1000));

    for (int p = 0; p < PHASES; p++) begin
      settle();
      unique case (p)
        0:       phase_hb = ffsa_pkg::HEADER_RESET;
        1:       phase_hb = '0;
        2:       phase_hb = '1;
        3:       phase_hb = ffsa_pkg::HB_W'(1);
        default: phase_hb = ffsa_pkg::HB_W'($urandom);
      endcase
      unique case (p)
        0, 4:    phase_cap = ffsa_pkg::LIMIT_RESET;
        1, 6:    phase_cap = '1;
        3:       phase_cap = '0;
        default: phase_cap = tracker.tail + ffsa_pkg::LIM_W'($urandom_range(0, 20000));
      endcase
      program_regs(phase_hb, phase_cap);
      fill_pct = (p % 2 == 0) ? 85 : 35;
      steady   = (p == 2 || p == 5);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ((p == 1 || p == 4) && k == 30) hold_off_req = 1'b1;
        r = $urandom_range(0, 99);
        if (r < fill_pct) begin
          r = $urandom_range(0, 99);
          if (r < 65) begin
            size = ffsa_pkg::ADDR_BITS'($urandom_range(0, 255));
          end else if (r < 93) begin
            size = ffsa_pkg::ADDR_BITS'($urandom_range(256, 4095));
          end else if (r < 97 && tracker.tail > 65536) begin
            // Too large for what is left of the heap.
            size = {4'hF, 16'($urandom)};
          end else begin
            size = '0;
          end
          request_alloc(size);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 80 && tracker.live > 0) begin
            addr = tracker.seg_start[$urandom_range(0, tracker.live - 1)];
          end else if (r < 90) begin
            addr = tracker.last_grant;
          end else begin
            addr = ffsa_pkg::ADDR_BITS'($urandom);
          end
          request_free(addr);
        end
        // Keep offering beats back to back in steady phases and while the result side holds off.
        if (!steady && !hold_off_req) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            n = 0;
          end else if (r < 92) begin
            n = $urandom_range(1, 3);
          end else begin
            n = $urandom_range(10, 60);
          end
          if (n > 0) pause_sender(n);
        end
      end
    end

    // Empty the table, fill the heap to its last byte, then one more zero-size
    // segment whose payload offset would fall outside the address range.
    settle();
    program_regs('0, ffsa_pkg::LIMIT_RESET);
    while (tracker.live > 0) request_free(tracker.seg_start[0]);
    if (tracker.tail < ffsa_pkg::ADDR_SPAN) begin
      request_alloc(ffsa_pkg::ADDR_BITS'(ffsa_pkg::ADDR_SPAN - tracker.tail));
    end
    request_alloc('0);

    settle();
    if (tracker.errors == 0 && tracker.grants_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* first_fit_segment_allocator_top.f */
+incdir+rtl
rtl/ffsa_pkg.sv
rtl/ffsa_cell.sv
rtl/ffsa_chain.sv
rtl/first_fit_segment_allocator_top.sv
tb/sv/first_fit_segment_allocator_top_test.sv
